// File: design/sit_pkg.sv
`timescale 1ns / 1ps
// Package for the segment intersection test core.
// Holds the fixed field widths, fixed-point constants and orientation codes.
package sit_pkg;
    localparam int FIELD_W   = 16;
    localparam int OUT_W     = 24;
    localparam int FRAC_BITS = 8;
    localparam int QUOT_BITS = OUT_W + 1;

    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ORI_COLLINEAR = 2'd0,
        ORI_CW        = 2'd1,
        ORI_CCW       = 2'd2
    } orient_t;
endpackage

// File: design/sit_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the segment intersection test core.
// Depends on sit_pkg for the field widths.
interface sit_pair_if;
    import sit_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  first_start_x;
    logic signed [FIELD_W-1:0]  first_start_y;
    logic signed [FIELD_W-1:0]  first_end_x;
    logic signed [FIELD_W-1:0]  first_end_y;
    logic signed [FIELD_W-1:0]  second_start_x;
    logic signed [FIELD_W-1:0]  second_start_y;
    logic signed [FIELD_W-1:0]  second_end_x;
    logic signed [FIELD_W-1:0]  second_end_y;

    modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                    second_start_x, second_start_y, second_end_x, second_end_y,
                    input ready);
    modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y,
                  output ready);
endinterface

interface sit_result_if;
    import sit_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     intersects;
    logic                     point_valid;
    logic signed [OUT_W-1:0]  cross_x;
    logic signed [OUT_W-1:0]  cross_y;

    modport source (output valid, intersects, point_valid, cross_x, cross_y, input ready);
    modport sink (input valid, intersects, point_valid, cross_x, cross_y, output ready);
endinterface

// File: design/segment_intersection_test_core.sv
`timescale 1ns / 1ps
// Segment intersection test core: orientation tests and fixed-point crossing point.
// Depends on sit_pkg and the channel interfaces in sit_if.sv.
//
// Usage: each item on the pairs channel carries the end points of two segments;
// the low COORD_BITS bits of each field are taken as a signed coordinate.
// Each pair gives exactly one item on the results channel: intersects,
// point_valid and the crossing point in signed fixed point with 8 fraction bits,
// truncated toward zero and saturated to 24 bits. Without a crossing point the
// coordinates are zero.
// From acceptance to the result a pair passes seven arithmetic stages,
// a 25-stage restoring divider that settles one quotient bit per stage, and
// the output register. Throughput is one pair per cycle unless results stall.
// Reset clears every valid bit, so the pipeline starts empty.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// pairs.ready drops in the same cycle; nothing is lost or repeated.
module segment_intersection_test_core #(
    parameter int COORD_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    sit_pair_if.sink     pairs,
    sit_result_if.source results
);
    import sit_pkg::*;

    localparam int N    = COORD_BITS;
    localparam int CW   = N + 1;
    localparam int PW   = 2 * N + 2;
    localparam int VW   = 2 * N + 3;
    localparam int LB   = N + 3;
    localparam int HB   = VW - LB;
    localparam int LPW  = LB + 1 + CW;
    localparam int HPW  = HB + CW;
    localparam int NXW  = 3 * N + 5;
    localparam int NUMW = NXW + FRAC_BITS;
    localparam int RW   = (NUMW > VW + QUOT_BITS + 1) ? NUMW : VW + QUOT_BITS + 1;
    localparam int QB   = QUOT_BITS;

    typedef logic signed [N-1:0]  coord_t;
    typedef logic signed [CW-1:0] diff_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [VW-1:0] wide_t;

    function automatic coord_t take(input logic [FIELD_W-1:0] f);
        logic [N-1:0] w;
        w = N'($unsigned(f));
        return coord_t'(w);
    endfunction

    function automatic logic in_box(input coord_t px, input coord_t py, input coord_t qx,
                                    input coord_t qy, input coord_t rx, input coord_t ry);
        logic x_ok;
        logic y_ok;
        x_ok = ((qx <= px) || (qx <= rx)) && ((qx >= px) || (qx >= rx));
        y_ok = ((qy <= py) || (qy <= ry)) && ((qy >= py) || (qy >= ry));
        return x_ok && y_ok;
    endfunction

    function automatic orient_t orient_of(input wide_t v);
        if (v == '0)
            return ORI_COLLINEAR;
        else if (!v[VW-1])
            return ORI_CW;
        else
            return ORI_CCW;
    endfunction

    logic adv;
    logic out_valid_reg;

    assign adv          = !out_valid_reg || results.ready;
    assign pairs.ready  = adv;

    // Stage 1: coordinates.
    logic   s1_valid_reg;
    coord_t ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg, dx_reg, dy_reg;

    // Stage 2: differences and bounding box tests.
    logic   s2_valid_reg;
    diff_t  td_reg [4][4];
    diff_t  a1_s2_reg, b1_s2_reg, a2_s2_reg, b2_s2_reg;
    coord_t ax_s2_reg, ay_s2_reg, cx_s2_reg, cy_s2_reg;
    logic [3:0] box_s2_reg;

    // Stage 3: products.
    logic   s3_valid_reg;
    prod_t  tp_reg [4][2];
    prod_t  m_a1ax_reg, m_b1ay_reg, m_a2cx_reg, m_b2cy_reg, m_a1b2_reg, m_a2b1_reg;
    diff_t  a1_s3_reg, b1_s3_reg, a2_s3_reg, b2_s3_reg;
    logic [3:0] box_s3_reg;

    // Stage 4: orientations, line constants and determinant.
    logic    s4_valid_reg;
    orient_t o_reg [4];
    wide_t   c1_reg, c2_reg, det_s4_reg;
    diff_t   a1_s4_reg, b1_s4_reg, a2_s4_reg, b2_s4_reg;
    logic [3:0] box_s4_reg;

    // Stage 5: partial products of the numerators.
    logic                    s5_valid_reg;
    logic signed [LPW-1:0]   plo_reg [4];
    logic signed [HPW-1:0]   phi_reg [4];
    wide_t                   det_s5_reg;
    logic                    gen_s5_reg;
    logic                    hit_s5_reg;

    // Stage 6: numerators.
    logic                    s6_valid_reg;
    logic signed [NXW-1:0]   nx_reg, ny_reg;
    wide_t                   det_s6_reg;
    logic                    gen_s6_reg;
    logic                    hit_s6_reg;

    // Stage 7: magnitudes for the divider.
    logic                    s7_valid_reg;
    logic [RW-1:0]           numx_reg, numy_reg;
    logic [VW-1:0]           dmag_reg;
    logic                    negx_reg, negy_reg;
    logic                    gen_s7_reg;
    logic                    hit_s7_reg;

    // Divider stages.
    logic          dv_reg   [QB];
    logic [RW-1:0] remx_reg [QB];
    logic [RW-1:0] remy_reg [QB];
    logic [VW-1:0] den_reg  [QB];
    logic [QB-1:0] qx_reg   [QB];
    logic [QB-1:0] qy_reg   [QB];
    logic          negx_d_reg [QB];
    logic          negy_d_reg [QB];
    logic          ovfx_reg [QB];
    logic          ovfy_reg [QB];
    logic          gen_d_reg [QB];
    logic          hit_d_reg [QB];

    logic                    intersects_reg;
    logic                    point_valid_reg;
    logic signed [OUT_W-1:0] cross_x_reg, cross_y_reg;

    logic signed [NXW-1:0]   pfull [4];
    logic                    gen_next;
    logic                    hit_next;
    logic [OUT_W-1:0]        cross_x_next, cross_y_next;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            pfull[k] = (NXW'(phi_reg[k]) <<< LB) + NXW'(plo_reg[k]);
        end
    end

    always_comb
    begin
        gen_next = (o_reg[0] != o_reg[1]) && (o_reg[2] != o_reg[3]) && (det_s4_reg != '0);
        hit_next = ((o_reg[0] == ORI_COLLINEAR) && box_s4_reg[0])
                || ((o_reg[1] == ORI_COLLINEAR) && box_s4_reg[1])
                || ((o_reg[2] == ORI_COLLINEAR) && box_s4_reg[2])
                || ((o_reg[3] == ORI_COLLINEAR) && box_s4_reg[3]);
    end

    function automatic logic [OUT_W-1:0] saturate(input logic [QB-1:0] q, input logic neg,
                                                  input logic ovf);
        logic [QB-1:0] lim_pos;
        logic [QB-1:0] lim_neg;
        logic [OUT_W-1:0] qn;
        lim_pos = QB'(SAT_POS);
        lim_neg = QB'(SAT_NEG);
        qn = OUT_W'(q);
        if (neg)
        begin
            if (ovf || (q > lim_neg))
                return SAT_NEG;
            return OUT_W'(0) - qn;
        end
        if (ovf || (q > lim_pos))
            return SAT_POS;
        return qn;
    endfunction

    always_comb
    begin
        cross_x_next = saturate(qx_reg[QB-1], negx_d_reg[QB-1], ovfx_reg[QB-1]);
        cross_y_next = saturate(qy_reg[QB-1], negy_d_reg[QB-1], ovfy_reg[QB-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pairs.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            out_valid_reg <= dv_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg <= take(pairs.first_start_x);
            ay_reg <= take(pairs.first_start_y);
            bx_reg <= take(pairs.first_end_x);
            by_reg <= take(pairs.first_end_y);
            cx_reg <= take(pairs.second_start_x);
            cy_reg <= take(pairs.second_start_y);
            dx_reg <= take(pairs.second_end_x);
            dy_reg <= take(pairs.second_end_y);

            td_reg[0][0] <= CW'(by_reg) - CW'(ay_reg);
            td_reg[0][1] <= CW'(cx_reg) - CW'(bx_reg);
            td_reg[0][2] <= CW'(bx_reg) - CW'(ax_reg);
            td_reg[0][3] <= CW'(cy_reg) - CW'(by_reg);
            td_reg[1][0] <= CW'(by_reg) - CW'(ay_reg);
            td_reg[1][1] <= CW'(dx_reg) - CW'(bx_reg);
            td_reg[1][2] <= CW'(bx_reg) - CW'(ax_reg);
            td_reg[1][3] <= CW'(dy_reg) - CW'(by_reg);
            td_reg[2][0] <= CW'(dy_reg) - CW'(cy_reg);
            td_reg[2][1] <= CW'(ax_reg) - CW'(dx_reg);
            td_reg[2][2] <= CW'(dx_reg) - CW'(cx_reg);
            td_reg[2][3] <= CW'(ay_reg) - CW'(dy_reg);
            td_reg[3][0] <= CW'(dy_reg) - CW'(cy_reg);
            td_reg[3][1] <= CW'(bx_reg) - CW'(dx_reg);
            td_reg[3][2] <= CW'(dx_reg) - CW'(cx_reg);
            td_reg[3][3] <= CW'(by_reg) - CW'(dy_reg);
            a1_s2_reg <= CW'(by_reg) - CW'(ay_reg);
            b1_s2_reg <= CW'(ax_reg) - CW'(bx_reg);
            a2_s2_reg <= CW'(dy_reg) - CW'(cy_reg);
            b2_s2_reg <= CW'(cx_reg) - CW'(dx_reg);
            ax_s2_reg <= ax_reg;
            ay_s2_reg <= ay_reg;
            cx_s2_reg <= cx_reg;
            cy_s2_reg <= cy_reg;
            box_s2_reg[0] <= in_box(ax_reg, ay_reg, cx_reg, cy_reg, bx_reg, by_reg);
            box_s2_reg[1] <= in_box(ax_reg, ay_reg, dx_reg, dy_reg, bx_reg, by_reg);
            box_s2_reg[2] <= in_box(cx_reg, cy_reg, ax_reg, ay_reg, dx_reg, dy_reg);
            box_s2_reg[3] <= in_box(cx_reg, cy_reg, bx_reg, by_reg, dx_reg, dy_reg);

            for (int k = 0; k < 4; k++)
            begin
                tp_reg[k][0] <= PW'(td_reg[k][0]) * PW'(td_reg[k][1]);
                tp_reg[k][1] <= PW'(td_reg[k][2]) * PW'(td_reg[k][3]);
            end
            m_a1ax_reg <= PW'(a1_s2_reg) * PW'(ax_s2_reg);
            m_b1ay_reg <= PW'(b1_s2_reg) * PW'(ay_s2_reg);
            m_a2cx_reg <= PW'(a2_s2_reg) * PW'(cx_s2_reg);
            m_b2cy_reg <= PW'(b2_s2_reg) * PW'(cy_s2_reg);
            m_a1b2_reg <= PW'(a1_s2_reg) * PW'(b2_s2_reg);
            m_a2b1_reg <= PW'(a2_s2_reg) * PW'(b1_s2_reg);
            a1_s3_reg  <= a1_s2_reg;
            b1_s3_reg  <= b1_s2_reg;
            a2_s3_reg  <= a2_s2_reg;
            b2_s3_reg  <= b2_s2_reg;
            box_s3_reg <= box_s2_reg;

            for (int k = 0; k < 4; k++)
            begin
                o_reg[k] <= orient_of(VW'(tp_reg[k][0]) - VW'(tp_reg[k][1]));
            end
            c1_reg     <= VW'(m_a1ax_reg) + VW'(m_b1ay_reg);
            c2_reg     <= VW'(m_a2cx_reg) + VW'(m_b2cy_reg);
            det_s4_reg <= VW'(m_a1b2_reg) - VW'(m_a2b1_reg);
            a1_s4_reg  <= a1_s3_reg;
            b1_s4_reg  <= b1_s3_reg;
            a2_s4_reg  <= a2_s3_reg;
            b2_s4_reg  <= b2_s3_reg;
            box_s4_reg <= box_s3_reg;

            plo_reg[0] <= LPW'($signed({1'b0, c1_reg[LB-1:0]})) * LPW'(b2_s4_reg);
            phi_reg[0] <= HPW'($signed(c1_reg[VW-1:LB])) * HPW'(b2_s4_reg);
            plo_reg[1] <= LPW'($signed({1'b0, c2_reg[LB-1:0]})) * LPW'(b1_s4_reg);
            phi_reg[1] <= HPW'($signed(c2_reg[VW-1:LB])) * HPW'(b1_s4_reg);
            plo_reg[2] <= LPW'($signed({1'b0, c2_reg[LB-1:0]})) * LPW'(a1_s4_reg);
            phi_reg[2] <= HPW'($signed(c2_reg[VW-1:LB])) * HPW'(a1_s4_reg);
            plo_reg[3] <= LPW'($signed({1'b0, c1_reg[LB-1:0]})) * LPW'(a2_s4_reg);
            phi_reg[3] <= HPW'($signed(c1_reg[VW-1:LB])) * HPW'(a2_s4_reg);
            det_s5_reg <= det_s4_reg;
            gen_s5_reg <= gen_next;
            hit_s5_reg <= hit_next;

            nx_reg     <= pfull[0] - pfull[1];
            ny_reg     <= pfull[2] - pfull[3];
            det_s6_reg <= det_s5_reg;
            gen_s6_reg <= gen_s5_reg;
            hit_s6_reg <= hit_s5_reg;

            numx_reg   <= RW'(nx_reg[NXW-1] ? $unsigned(-nx_reg) : $unsigned(nx_reg))
                          << FRAC_BITS;
            numy_reg   <= RW'(ny_reg[NXW-1] ? $unsigned(-ny_reg) : $unsigned(ny_reg))
                          << FRAC_BITS;
            dmag_reg   <= det_s6_reg[VW-1] ? $unsigned(-det_s6_reg) : $unsigned(det_s6_reg);
            negx_reg   <= nx_reg[NXW-1] ^ det_s6_reg[VW-1];
            negy_reg   <= ny_reg[NXW-1] ^ det_s6_reg[VW-1];
            gen_s7_reg <= gen_s6_reg;
            hit_s7_reg <= hit_s6_reg;

            intersects_reg  <= gen_d_reg[QB-1] || hit_d_reg[QB-1];
            point_valid_reg <= gen_d_reg[QB-1];
            cross_x_reg     <= gen_d_reg[QB-1] ? $signed(cross_x_next) : '0;
            cross_y_reg     <= gen_d_reg[QB-1] ? $signed(cross_y_next) : '0;
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int SH = QB - 1 - j;
        logic [RW-1:0] rx_in, ry_in;
        logic [VW-1:0] d_in;
        logic [QB-1:0] qx_in, qy_in;
        logic [RW-1:0] dsh;

        if (j == 0)
        begin : g_first
            assign rx_in = numx_reg;
            assign ry_in = numy_reg;
            assign d_in  = dmag_reg;
            assign qx_in = '0;
            assign qy_in = '0;
        end
        else
        begin : g_next
            assign rx_in = remx_reg[j-1];
            assign ry_in = remy_reg[j-1];
            assign d_in  = den_reg[j-1];
            assign qx_in = qx_reg[j-1];
            assign qy_in = qy_reg[j-1];
        end

        assign dsh = RW'(d_in) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[j] <= 1'b0;
            else if (adv)
                dv_reg[j] <= (j == 0) ? s7_valid_reg : dv_reg[(j == 0) ? 0 : j-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                remx_reg[j] <= (rx_in >= dsh) ? rx_in - dsh : rx_in;
                remy_reg[j] <= (ry_in >= dsh) ? ry_in - dsh : ry_in;
                qx_reg[j]   <= qx_in | (QB'(rx_in >= dsh) << SH);
                qy_reg[j]   <= qy_in | (QB'(ry_in >= dsh) << SH);
                den_reg[j]  <= d_in;
                if (j == 0)
                begin
                    ovfx_reg[j]   <= rx_in >= (RW'(d_in) << QB);
                    ovfy_reg[j]   <= ry_in >= (RW'(d_in) << QB);
                    negx_d_reg[j] <= negx_reg;
                    negy_d_reg[j] <= negy_reg;
                    gen_d_reg[j]  <= gen_s7_reg;
                    hit_d_reg[j]  <= hit_s7_reg;
                end
                else
                begin
                    ovfx_reg[j]   <= ovfx_reg[(j == 0) ? 0 : j-1];
                    ovfy_reg[j]   <= ovfy_reg[(j == 0) ? 0 : j-1];
                    negx_d_reg[j] <= negx_d_reg[(j == 0) ? 0 : j-1];
                    negy_d_reg[j] <= negy_d_reg[(j == 0) ? 0 : j-1];
                    gen_d_reg[j]  <= gen_d_reg[(j == 0) ? 0 : j-1];
                    hit_d_reg[j]  <= hit_d_reg[(j == 0) ? 0 : j-1];
                end
            end
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.intersects  = intersects_reg;
    assign results.point_valid = point_valid_reg;
    assign results.cross_x     = cross_x_reg;
    assign results.cross_y     = cross_y_reg;

    a_point_implies_hit: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (!results.point_valid || results.intersects))
        else $error("A crossing point was reported without an intersection.");

    a_no_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.point_valid) |->
        (results.cross_x == '0 && results.cross_y == '0))
        else $error("Crossing coordinates are not zero without a crossing point.");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.ready) |-> !pairs.ready)
        else $error("The pipeline took an item while the output was stalled.");

    a_last_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && dv_reg[QB-1]) |=> out_valid_reg)
        else $error("An item in the last divider stage did not reach the output.");
endmodule
